// File: src/bitfield_pixel_converter_assert.svh
// assertion macros for the bitfield pixel converter
`ifndef BITFIELD_PIXEL_CONVERTER_ASSERT_SVH
`define BITFIELD_PIXEL_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// checked under reset qualification
`define BPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPC_ASSERT(lbl, prop, msg)
`define BPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/bpc_pkg.sv
// shared types, register codes and helper functions of the pixel converter
package bpc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MASK   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_BYTES = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_FORMAT  = 3'd5;

	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;
	localparam int CH_A = 3;

	localparam logic FMT_RGB565   = 1'b0;
	localparam logic FMT_ARGB8888 = 1'b1;

	// reset masks, alpha in the top entry
	localparam logic [3:0][31:0] RESET_MASK = {
		32'hFF00_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000
	};
	localparam logic [2:0] RESET_SOURCE_BYTES = 3'd4;
	localparam logic       RESET_DEST_FORMAT  = FMT_ARGB8888;
	localparam logic [7:0] ALPHA_OPAQUE       = 8'd255;

	typedef struct packed {
		logic [31:0] mask_sh;
		logic [4:0]  shift;
		logic [5:0]  span;
	} bpc_chan_t;

	typedef struct packed {
		bpc_chan_t [3:0] chan;
		logic [2:0]      source_bytes;
		logic            dest_format;
	} bpc_cfg_t;

	typedef struct packed {
		logic [3:0][31:0] chan;
		logic             alpha_opaque;
		logic             row_end;
	} bpc_s1_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       row_end;
	} bpc_s2_t;

	// shift, right-aligned mask and span of one channel mask
	function automatic bpc_chan_t f_derive(input logic [31:0] m);
		bpc_chan_t  d;
		logic [4:0] lo;
		logic [4:0] hi;
		lo = '0;
		hi = '0;
		for (int i = 31; i >= 0; i--) begin
			if (m[i]) lo = 5'(i);
		end
		for (int i = 0; i < 32; i++) begin
			if (m[i]) hi = 5'(i);
		end
		d.shift   = lo;
		d.mask_sh = m >> lo;
		d.span    = (m == '0) ? 6'd0 : ({1'b0, hi} + 6'd1 - {1'b0, lo});
		return d;
	endfunction

	// bring a channel of width from to width to (at most eight)
	function automatic logic [7:0] f_rescale(input logic [31:0] c, input logic [5:0] from,
			input logic [3:0] to);
		logic [6:0]  f2;
		logic [6:0]  t7;
		logic [31:0] r;
		logic [7:0]  keep;
		f2 = {from, 1'b0};
		t7 = {3'b000, to};
		if (from <= {2'b00, to}) begin
			r = c << ({2'b00, to} - from);
			if (f2 >= t7) r = r | (c >> (f2 - t7));
		end else begin
			r = c >> (from - {2'b00, to});
		end
		keep = 8'((9'd1 << to) - 9'd1);
		return r[7:0] & keep;
	endfunction

endpackage

// File: src/bpc_cfg.sv
// configuration registers with per-channel shift and span derivation
module bpc_cfg
	import bpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output bpc_cfg_t               cfg
);

	bpc_chan_t [3:0] chan_q;
	logic [2:0]      source_bytes_q;
	logic            dest_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				chan_q[i] <= f_derive(RESET_MASK[i]);
			end
			source_bytes_q <= RESET_SOURCE_BYTES;
			dest_format_q  <= RESET_DEST_FORMAT;
		end else if (cfg_write) begin
			unique case (cfg_index) inside
				REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK, REG_ALPHA_MASK: begin
					chan_q[cfg_index[1:0]] <= f_derive(cfg_data);
				end
				REG_SOURCE_BYTES: source_bytes_q <= cfg_data[2:0];
				REG_DEST_FORMAT:  dest_format_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.chan         = chan_q;
	assign cfg.source_bytes = source_bytes_q;
	assign cfg.dest_format  = dest_format_q;

endmodule

// File: src/bpc_extract.sv
// stage 1: source width trim and channel field extraction
module bpc_extract
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bpc_cfg_t    cfg,
	input  logic        up_valid,
	output logic        up_ready,
	input  logic [31:0] source_pixel,
	input  logic        row_end_in,
	output logic        dn_valid,
	input  logic        dn_ready,
	output bpc_s1_t     dn_data
);

	logic        valid_s1;
	bpc_s1_t     data_s1;
	logic        two_bytes;
	logic        four_bytes;
	logic [31:0] pix;
	bpc_s1_t     nxt;

	always_comb begin
		// 0 and 1 act as 2, 5 to 7 act as 4
		two_bytes  = (cfg.source_bytes <= 3'd2);
		four_bytes = (cfg.source_bytes >= 3'd4);
		if (two_bytes)       pix = {16'h0000, source_pixel[15:0]};
		else if (four_bytes) pix = source_pixel;
		else                 pix = {8'h00, source_pixel[23:0]};
		for (int i = 0; i < 4; i++) begin
			nxt.chan[i] = (pix >> cfg.chan[i].shift) & cfg.chan[i].mask_sh;
		end
		nxt.alpha_opaque = !four_bytes;
		nxt.row_end      = row_end_in;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// File: src/bpc_scale.sv
// stage 2: widen or narrow each channel to the target width
module bpc_scale
	import bpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  bpc_cfg_t cfg,
	input  logic     up_valid,
	output logic     up_ready,
	input  bpc_s1_t  up_data,
	output logic     dn_valid,
	input  logic     dn_ready,
	output bpc_s2_t  dn_data
);

	logic       valid_s2;
	bpc_s2_t    data_s2;
	logic [3:0] to_rb;
	logic [3:0] to_g;
	bpc_s2_t    nxt;

	always_comb begin
		to_rb = (cfg.dest_format == FMT_ARGB8888) ? 4'd8 : 4'd5;
		to_g  = (cfg.dest_format == FMT_ARGB8888) ? 4'd8 : 4'd6;
		nxt.r = f_rescale(up_data.chan[CH_R], cfg.chan[CH_R].span, to_rb);
		nxt.g = f_rescale(up_data.chan[CH_G], cfg.chan[CH_G].span, to_g);
		nxt.b = f_rescale(up_data.chan[CH_B], cfg.chan[CH_B].span, to_rb);
		// an empty alpha mask has span zero and scales to zero
		nxt.a = up_data.alpha_opaque ? ALPHA_OPAQUE :
			f_rescale(up_data.chan[CH_A], cfg.chan[CH_A].span, 4'd8);
		nxt.row_end = up_data.row_end;
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= nxt;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

// File: src/bpc_pack.sv
// stage 3: pack channels into the output word, output register
module bpc_pack
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bpc_cfg_t    cfg,
	input  logic        up_valid,
	output logic        up_ready,
	input  bpc_s2_t     up_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packed_pixel,
	output logic        row_end_out
);

	logic        valid_s3;
	logic [31:0] pixel_s3;
	logic        row_end_s3;
	logic [31:0] nxt;

	always_comb begin
		if (cfg.dest_format == FMT_ARGB8888) begin
			nxt = {up_data.a, up_data.r, up_data.g, up_data.b};
		end else begin
			nxt = {16'h0000, up_data.r[4:0], up_data.g[5:0], up_data.b[4:0]};
		end
	end

	assign up_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			pixel_s3   <= nxt;
			row_end_s3 <= up_data.row_end;
		end
	end

	assign out_valid    = valid_s3;
	assign packed_pixel = pixel_s3;
	assign row_end_out  = row_end_s3;

endmodule

// File: src/bitfield_pixel_converter.sv
// bit-field pixel converter: three-stage pipeline from masked source pixel to rgb565/argb8888
// path: a request accepted on in_ready passes the s1, s2 and s3 registers to out_valid (three stages)
// throughput: one pixel per cycle while out_ready is high; every stage holds one request and stalls only when full
// in_ready follows out_ready combinationally through the stage valid bits
// reset (arst_n low, asynchronous) empties the pipe and loads the default argb8888 masks
// mask writes derive shift and span in the same cycle, so a request may follow at once
module bitfield_pixel_converter
	import bpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// source pixel requests
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            source_pixel,
	input  logic                   row_end_in,
	// converted pixel requests
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            packed_pixel,
	output logic                   row_end_out
);

`include "bitfield_pixel_converter_assert.svh"

	// live configuration, to be held constant by the user while requests are in flight; the block does not enforce it
	bpc_cfg_t cfg;

	// stage-to-stage handshake
	logic    valid_s1;
	logic    ready_s1;
	bpc_s1_t data_s1;
	logic    valid_s2;
	logic    ready_s2;
	bpc_s2_t data_s2;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1: trim to source width, shift each field down and mask it
	bpc_extract u_extract (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.up_valid     (in_valid),
		.up_ready     (in_ready),
		.source_pixel (source_pixel),
		.row_end_in   (row_end_in),
		.dn_valid     (valid_s1),
		.dn_ready     (ready_s1),
		.dn_data      (data_s1)
	);

	// stage 2: bit replication when widening, right shift when narrowing
	bpc_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (valid_s1),
		.up_ready (ready_s1),
		.up_data  (data_s1),
		.dn_valid (valid_s2),
		.dn_ready (ready_s2),
		.dn_data  (data_s2)
	);

	// stage 3: pack and hold the result until taken
	bpc_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.up_valid     (valid_s2),
		.up_ready     (ready_s2),
		.up_data      (data_s2),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_pixel (packed_pixel),
		.row_end_out  (row_end_out)
	);

	// a free output side must open the whole pipe
	`BPC_ASSERT(a_ready_chain, out_ready |-> in_ready, "input stalled with output open")
	// with the output open while the request moves from stage 1 through stage 2, it reaches the output register
	`BPC_ASSERT(a_latency,
		(in_valid && in_ready) ##1 out_ready [*2] |=> out_valid,
		"request lost in pipe")
	// rgb565 results are zero-extended
	`BPC_ASSERT(a_565_upper,
		(out_valid && cfg.dest_format == FMT_RGB565) |-> (packed_pixel[31:16] == 16'h0000),
		"rgb565 upper half not zero")
	// derived span is zero exactly for an empty mask
	`BPC_ASSERT(a_alpha_span,
		(cfg.chan[CH_A].span == 6'd0) == (cfg.chan[CH_A].mask_sh == 32'd0),
		"alpha span mismatch")

endmodule
